// ----- hw/rtl/indexed_list_insert_remove_assert.svh -----
// ----------------------------------------------------------------------------
// indexed list assertion macros
// shared assertion forms for the indexed list block
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ILIR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ilir assertion failed");

// next-cycle implication, disabled during reset
`define ILIR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ilir assertion failed");

`endif

// ----- hw/rtl/ilir_pkg.sv -----
// ----------------------------------------------------------------------------
// ilir_pkg
// shared constants, codes and control types of the indexed list block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilir_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 7;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND   = 2'd0,
    KIND_INSERT   = 2'd1,
    KIND_POP_AT   = 2'd2,
    KIND_POP_LAST = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_M1,
    RD_PTR_P1
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_PUT,
    S_UP_RD,
    S_UP_WR,
    S_POP_RD,
    S_POP_CAP,
    S_DN_RD,
    S_DN_WR,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load_op;
    logic    start;
    logic    ptr_inc;
    logic    ptr_dec;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_rdata;
    logic    cap_pop;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  err;
    logic  up_more;
    logic  down_more;
    logic  out_free;
  } stat_t;

endpackage

// ----- hw/rtl/ilir_in_if.sv -----
// ----------------------------------------------------------------------------
// ilir_in_if
// request channel: operation kind, value and position
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ilir_in_if import ilir_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] item_value;
  logic [POS_W-1:0]         position;

  modport source (output valid, kind, item_value, position, input ready);
  modport sink   (input valid, kind, item_value, position, output ready);
endinterface

// ----- hw/rtl/ilir_out_if.sv -----
// ----------------------------------------------------------------------------
// ilir_out_if
// result channel: popped value, status and entry count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ilir_out_if import ilir_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic [STATUS_W-1:0]      status;
  logic [POS_W-1:0]         entry_count;

  modport source (output valid, popped_value, status, entry_count, input ready);
  modport sink   (input valid, popped_value, status, entry_count, output ready);
endinterface

// ----- hw/rtl/ilir_ram.sv -----
// ----------------------------------------------------------------------------
// ilir_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/ilir_ctrl.sv -----
// ----------------------------------------------------------------------------
// ilir_ctrl
// sequencer for append, insert and pop operations
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilir_ctrl import ilir_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.err) begin
          state_nxt = S_DONE;
        end else begin
          case (stat.kind)
            KIND_APPEND: state_nxt = S_PUT;
            KIND_INSERT: state_nxt = S_UP_RD;
            default:     state_nxt = S_POP_RD;
          endcase
        end
      end
      S_PUT:     state_nxt = S_DONE;
      S_UP_RD:   state_nxt = stat.up_more ? S_UP_WR : S_PUT;
      S_UP_WR:   state_nxt = S_UP_RD;
      S_POP_RD:  state_nxt = S_POP_CAP;
      S_POP_CAP: state_nxt = S_DN_RD;
      S_DN_RD:   state_nxt = stat.down_more ? S_DN_WR : S_DONE;
      S_DN_WR:   state_nxt = S_DN_RD;
      S_DONE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.rd_sel = RD_PTR;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_op = in_valid;
      end
      S_CHECK: begin
        cmd.start = 1'b1;
      end
      S_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_UP_RD: begin
        cmd.rd_sel = RD_PTR_M1;
      end
      S_UP_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_rdata = 1'b1;
        cmd.ptr_dec  = 1'b1;
      end
      S_POP_RD: begin
        cmd.rd_sel = RD_PTR;
      end
      S_POP_CAP: begin
        cmd.cap_pop = 1'b1;
      end
      S_DN_RD: begin
        cmd.rd_sel  = RD_PTR_P1;
        cmd.cnt_dec = !stat.down_more;
      end
      S_DN_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_rdata = 1'b1;
        cmd.ptr_inc  = 1'b1;
      end
      S_DONE: begin
        cmd.load_out = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/ilir_dpath.sv -----
// ----------------------------------------------------------------------------
// ilir_dpath
// entry store, count, shift pointer and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_list_insert_remove_assert.svh"

module ilir_dpath import ilir_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [DATA_W-1:0] in_item_value,
  input  logic [POS_W-1:0]         in_position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_popped_value,
  output logic [STATUS_W-1:0]      out_status,
  output logic [POS_W-1:0]         out_entry_count
);

  localparam int CNT1_W = CNT_W + 1;

  kind_t                     op_kind_r;
  logic signed [DATA_W-1:0]  op_value_r;
  logic [POS_W-1:0]          op_pos_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          ptr_r;
  logic [CNT_W-1:0]          ptr_load;
  status_t                   res_status_r;
  logic [DATA_W-1:0]         popped_r;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_popped_r;
  status_t                   out_status_r;
  logic [CNT_W-1:0]          out_count_r;
  status_t                   req_status;
  logic [CMP_W-1:0]          pos_x;
  logic [CMP_W-1:0]          cnt_x;
  logic [CMP_W-1:0]          ptr_x;
  logic                      full;
  logic                      empty;
  logic [CNT_W-1:0]          ptr_m1;
  logic [CNT_W-1:0]          ptr_p1;
  logic [IDX_W-1:0]          rd_addr;
  logic [DATA_W-1:0]         rd_data;
  logic [DATA_W-1:0]         wr_data;

  assign pos_x = CMP_W'(op_pos_r);
  assign cnt_x = CMP_W'(count_r);
  assign ptr_x = CMP_W'(ptr_r);
  assign full  = count_r >= CNT_W'(CAPACITY);
  assign empty = count_r == '0;

  // request check, range before full, empty before range
  always_comb begin
    req_status = STATUS_OK;
    case (op_kind_r)
      KIND_APPEND: begin
        if (full) begin
          req_status = STATUS_FULL;
        end
      end
      KIND_INSERT: begin
        if (pos_x > cnt_x) begin
          req_status = STATUS_RANGE;
        end else if (full) begin
          req_status = STATUS_FULL;
        end
      end
      KIND_POP_AT: begin
        if (empty) begin
          req_status = STATUS_EMPTY;
        end else if (pos_x >= cnt_x) begin
          req_status = STATUS_RANGE;
        end
      end
      default: begin
        if (empty) begin
          req_status = STATUS_EMPTY;
        end
      end
    endcase
  end

  // start point of the shift pointer
  always_comb begin
    case (op_kind_r)
      KIND_POP_AT:   ptr_load = CNT_W'(op_pos_r);
      KIND_POP_LAST: ptr_load = count_r - 1'b1;
      default:       ptr_load = count_r;
    endcase
  end

  assign ptr_m1 = ptr_r - 1'b1;
  assign ptr_p1 = ptr_r + 1'b1;

  always_comb begin
    case (cmd.rd_sel)
      RD_PTR_M1: rd_addr = ptr_m1[IDX_W-1:0];
      RD_PTR_P1: rd_addr = ptr_p1[IDX_W-1:0];
      default:   rd_addr = ptr_r[IDX_W-1:0];
    endcase
  end

  assign wr_data = cmd.wr_rdata ? rd_data : DATA_W'(op_value_r);

  ilir_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (ptr_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // operand and working registers
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_kind_r  <= kind_t'(in_kind);
      op_value_r <= in_item_value;
      op_pos_r   <= in_position;
      popped_r   <= '0;
    end else if (cmd.cap_pop) begin
      popped_r   <= rd_data;
    end
    if (cmd.start) begin
      res_status_r <= req_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - 1'b1;
      end
      if (cmd.start) begin
        ptr_r <= ptr_load;
      end else if (cmd.ptr_inc) begin
        ptr_r <= ptr_p1;
      end else if (cmd.ptr_dec) begin
        ptr_r <= ptr_m1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_popped_r <= signed'(popped_r);
      out_status_r <= res_status_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = POS_W'(out_count_r);

  assign stat.kind      = op_kind_r;
  assign stat.err       = req_status != STATUS_OK;
  assign stat.up_more   = ptr_x > pos_x;
  assign stat.down_more = (CNT1_W'(ptr_r) + 1'b1) < CNT1_W'(count_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  `ILIR_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `ILIR_ASSERT_IMP(a_inc_room, clk, rst_n, cmd.cnt_inc, count_r < CNT_W'(CAPACITY))
  `ILIR_ASSERT_IMP(a_dec_some, clk, rst_n, cmd.cnt_dec, count_r != '0)
  `ILIR_ASSERT_IMP(a_wr_in_range, clk, rst_n, cmd.wr_en, ptr_r < CNT_W'(CAPACITY))
  `ILIR_ASSERT_NXT(a_cnt_hold, clk, rst_n, !cmd.cnt_inc && !cmd.cnt_dec, $stable(count_r))

endmodule

// ----- hw/rtl/indexed_list_insert_remove.sv -----
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// a failed request goes straight to the result; insert and pop shift the entries
// between the position and the end, each moved entry with one ram read and one
// ram write; one request at a time, the next transfer is taken in the cycle after
// the result is loaded
// reset (synchronous, active low) empties the list; entry contents persist
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_insert_remove import ilir_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  ilir_in_if.sink  in_if,
  ilir_out_if.source out_if
);

  // control and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // the sequencer takes a request transfer only while idle; the result
  // register sits in the datapath, so a waiting result never blocks the
  // next request from being checked and worked on
  ilir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entries live in a single-write, single-read ram; shifts walk a pointer
  // from the end towards the position (insert) or from the position towards
  // the end (pop), one entry per read and write pair
  ilir_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_if.kind),
    .in_item_value    (in_if.item_value),
    .in_position      (in_if.position),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_popped_value (out_if.popped_value),
    .out_status       (out_if.status),
    .out_entry_count  (out_if.entry_count)
  );

endmodule
